[hdl/tbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Texture bilinear resampler package
// Field widths, register map, command codes and sequencer states shared by
// the resampler core.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int CMD_W     = 1;
    localparam int COORD_W   = 11;
    localparam int PIX_W     = 32;
    localparam int IN_DIM_W  = 9;
    localparam int OUT_DIM_W = 12;
    localparam int FRAC_W    = 16;
    localparam int MB_W      = FRAC_W + 1;
    localparam int CH_W      = 8;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;
    localparam int CNT_W     = 4;

    localparam logic [CMD_W-1:0] CMD_STORE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUALITY    = 3'd4;

    localparam logic [IN_DIM_W-1:0]  RST_IN_DIM  = 9'd256;
    localparam logic [OUT_DIM_W-1:0] RST_OUT_DIM = 12'd256;

    localparam logic [CNT_W-1:0] FETCH_LAST = 4'd4;
    localparam logic [CNT_W-1:0] LERP_LAST  = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX,
        S_MULX,
        S_XCAP,
        S_DIVY,
        S_MULY,
        S_YCAP,
        S_FETCH,
        S_LERP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[hdl/tbr_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Unsigned quotient of a DW-bit dividend by a nonzero VW-bit divisor, one
// quotient bit per cycle; o_done pulses for one cycle with the quotient held.
// ----------------------------------------------------------------------------
module tbr_div #(
    parameter int DW = 25,
    parameter int VW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [DW-1:0] r_quo;

    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]} - {1'b0, r_dvs};
        fits  = ~trial[VW];
        n_rem = fits ? trial[VW-1:0] : {r_rem[VW-2:0], r_quo[DW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

[hdl/texture_bilinear_resampler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Texture bilinear resampler core
// Holds an RGBA source image and returns bilinear or nearest RGBA samples of a
// scaled destination image, stepping through the source in 9.16 fixed point at the default sizes.
// ----------------------------------------------------------------------------
// A store transfer writes one source pixel and is done in its accept cycle.
// A compute transfer runs a sequencer over one serial divider and one shared
// multiplier: two divisions of Q = max(clog2(MAX_IN_WIDTH+1),
// clog2(MAX_IN_HEIGHT+1)) + 16 bits each, four reads from the
// image memory and, in bilinear mode, twelve channel lerps on the
// multiplier. The input is not ready while a compute transfer runs. The
// result sits in an output register, so a new transfer is taken while it
// waits. Entries never stored read as garbage.
// ----------------------------------------------------------------------------
module texture_bilinear_resampler_core #(
    parameter int MAX_IN_WIDTH  = 256,
    parameter int MAX_IN_HEIGHT = 256,
    parameter int MAX_OUT_DIM   = 2048
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tbr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tbr_pkg::APB_DW-1:0]   pwdata,
    output logic      [tbr_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [tbr_pkg::CMD_W-1:0]    i_command,
    input  wire logic [tbr_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic [tbr_pkg::COORD_W-1:0]  i_coord_y,
    input  wire logic [tbr_pkg::PIX_W-1:0]    i_pixel_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [tbr_pkg::PIX_W-1:0]    o_out_pixel
);

    import tbr_pkg::*;

    localparam int IWW   = $clog2(MAX_IN_WIDTH + 1);
    localparam int IHW   = $clog2(MAX_IN_HEIGHT + 1);
    localparam int ODW   = $clog2(MAX_OUT_DIM + 1);
    localparam int DIMW  = (IWW > IHW) ? IWW : IHW;
    localparam int DW    = DIMW + FRAC_W;
    localparam int PW    = DW + 1 + MB_W;
    localparam int SW    = PW - FRAC_W;
    localparam int XW    = $clog2(MAX_IN_WIDTH);
    localparam int YW    = $clog2(MAX_IN_HEIGHT);
    localparam int DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [IN_DIM_W-1:0]  r_in_width;
    logic [IN_DIM_W-1:0]  r_in_height;
    logic [OUT_DIM_W-1:0] r_out_width;
    logic [OUT_DIM_W-1:0] r_out_height;
    logic                 r_quality;

    logic [IWW-1:0] eff_iw;
    logic [IHW-1:0] eff_ih;
    logic [ODW-1:0] eff_ow;
    logic [ODW-1:0] eff_oh;

    // sequencer
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_div_wait;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;

    // item datapath
    logic [COORD_W-1:0]    r_cx;
    logic [COORD_W-1:0]    r_cy;
    logic [DW-1:0]         r_step_x;
    logic [DW-1:0]         r_step_y;
    logic signed [PW-1:0]  r_prod;
    logic [XW-1:0]         r_xi;
    logic [XW-1:0]         r_x1;
    logic [YW-1:0]         r_yi;
    logic [YW-1:0]         r_y1;
    logic [FRAC_W-1:0]     r_fx;
    logic [FRAC_W-1:0]     r_fy;
    logic [PIX_W-1:0]      r_pix [0:3];
    logic [PIX_W-1:0]      r_r0;
    logic [PIX_W-1:0]      r_r1;
    logic [PIX_W-1:0]      r_res;
    logic [CH_W-1:0]       r_la;
    logic [CNT_W-1:0]      r_lk;
    logic                  r_lv;

    // image memory
    logic [PIX_W-1:0] r_mem [0:DEPTH-1];
    logic [PIX_W-1:0] r_rd;

    // control outputs
    logic              in_ready;
    logic              accept;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [XW-1:0]     rd_x;
    logic [YW-1:0]     rd_y;
    logic              div_start;
    logic              div_done;
    logic [DW-1:0]     div_dividend;
    logic [ODW-1:0]    div_divisor;
    logic [DW-1:0]     div_quotient;
    logic signed [DW:0]       mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic              lerp_issue;
    logic              out_load;
    logic              fetch_cap;

    // lerp operands
    logic [PIX_W-1:0]  src_a;
    logic [PIX_W-1:0]  src_b;
    logic [FRAC_W-1:0] src_frac;
    logic [CH_W-1:0]   a_byte;
    logic [CH_W-1:0]   b_byte;
    logic [CH_W:0]     diff;
    logic [CH_W-1:0]   pp_val;

    // position capture
    logic [PW-1:0]   pos_sum;
    logic [SW-1:0]   cap_int;
    logic [DIMW-1:0] cap_dim;
    logic [DIMW-1:0] cap_pos;
    logic            cap_next;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= RST_IN_DIM;
            r_in_height  <= RST_IN_DIM;
            r_out_width  <= RST_OUT_DIM;
            r_out_height <= RST_OUT_DIM;
            r_quality    <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[APB_AW-1:2])
                REG_IN_WIDTH:   r_in_width   <= pwdata[IN_DIM_W-1:0];
                REG_IN_HEIGHT:  r_in_height  <= pwdata[IN_DIM_W-1:0];
                REG_OUT_WIDTH:  r_out_width  <= pwdata[OUT_DIM_W-1:0];
                REG_OUT_HEIGHT: r_out_height <= pwdata[OUT_DIM_W-1:0];
                REG_QUALITY:    r_quality    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_IN_WIDTH:   prdata = APB_DW'(r_in_width);
            REG_IN_HEIGHT:  prdata = APB_DW'(r_in_height);
            REG_OUT_WIDTH:  prdata = APB_DW'(r_out_width);
            REG_OUT_HEIGHT: prdata = APB_DW'(r_out_height);
            REG_QUALITY:    prdata = APB_DW'(r_quality);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (r_in_width == '0)
            eff_iw = IWW'(1);
        else if (32'(r_in_width) > 32'(MAX_IN_WIDTH))
            eff_iw = IWW'(MAX_IN_WIDTH);
        else
            eff_iw = IWW'(r_in_width);

        if (r_in_height == '0)
            eff_ih = IHW'(1);
        else if (32'(r_in_height) > 32'(MAX_IN_HEIGHT))
            eff_ih = IHW'(MAX_IN_HEIGHT);
        else
            eff_ih = IHW'(r_in_height);

        if (r_out_width == '0)
            eff_ow = ODW'(1);
        else if (32'(r_out_width) > 32'(MAX_OUT_DIM))
            eff_ow = ODW'(MAX_OUT_DIM);
        else
            eff_ow = ODW'(r_out_width);

        if (r_out_height == '0)
            eff_oh = ODW'(1);
        else if (32'(r_out_height) > 32'(MAX_OUT_DIM))
            eff_oh = ODW'(MAX_OUT_DIM);
        else
            eff_oh = ODW'(r_out_height);
    end

    // ------------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------------
    tbr_div #(
        .DW (DW),
        .VW (ODW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_command == CMD_COMPUTE)
                    n_state = S_DIVX;
            end
            S_DIVX: begin
                if (div_done)
                    n_state = S_MULX;
            end
            S_MULX: n_state = S_XCAP;
            S_XCAP: n_state = r_quality ? S_DIVY : S_MULY;
            S_DIVY: begin
                if (div_done)
                    n_state = r_quality ? S_MULY : S_YCAP;
            end
            S_MULY: n_state = r_quality ? S_YCAP : S_DIVY;
            S_YCAP: n_state = S_FETCH;
            S_FETCH: begin
                if (r_cnt == FETCH_LAST)
                    n_state = r_quality ? S_LERP : S_DONE;
            end
            S_LERP: begin
                if (r_cnt == LERP_LAST)
                    n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------------
    always_comb begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = eff_oh;
        mul_a        = '0;
        mul_b        = '0;
        lerp_issue   = 1'b0;
        out_load     = 1'b0;
        fetch_cap    = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_DIVX: begin
                div_start    = ~r_div_wait;
                div_dividend = DW'({eff_iw, {FRAC_W{1'b0}}});
                div_divisor  = eff_ow;
            end
            S_MULX: begin
                mul_a = {1'b0, r_step_x};
                mul_b = {{(MB_W-COORD_W){1'b0}}, r_cx};
            end
            S_DIVY: begin
                div_start    = ~r_div_wait;
                div_dividend = r_quality ? DW'({eff_ih, {FRAC_W{1'b0}}})
                                         : r_prod[DW-1:0];
            end
            S_MULY: begin
                mul_a = r_quality ? {1'b0, r_step_y} : {{(DW+1-IHW){1'b0}}, eff_ih};
                mul_b = {{(MB_W-COORD_W){1'b0}}, r_cy};
            end
            S_FETCH: fetch_cap = (r_cnt != '0);
            S_LERP: begin
                lerp_issue = (r_cnt != LERP_LAST);
                mul_a      = {{(DW-CH_W){diff[CH_W]}}, diff};
                mul_b      = {1'b0, src_frac};
            end
            S_DONE: out_load = ~r_out_valid | i_out_ready;
            default: begin
            end
        endcase
    end

    assign accept   = in_ready & i_in_valid;
    assign mem_we   = accept && (i_command == CMD_STORE) &&
                      (32'(i_coord_x) < 32'(MAX_IN_WIDTH)) &&
                      (32'(i_coord_y) < 32'(MAX_IN_HEIGHT));
    assign wr_addr  = AW'(32'(i_coord_y) * 32'(MAX_IN_WIDTH) + 32'(i_coord_x));
    assign rd_x     = r_cnt[0] ? r_x1 : r_xi;
    assign rd_y     = r_cnt[1] ? r_y1 : r_yi;
    assign rd_addr  = AW'(32'(rd_y) * 32'(MAX_IN_WIDTH) + 32'(rd_x));

    // ------------------------------------------------------------------------
    // lerp operand select and write back
    // ------------------------------------------------------------------------
    always_comb begin
        case (r_cnt[3:2])
            2'd0: begin
                src_a    = r_pix[0];
                src_b    = r_pix[1];
                src_frac = r_fx;
            end
            2'd1: begin
                src_a    = r_pix[2];
                src_b    = r_pix[3];
                src_frac = r_fx;
            end
            default: begin
                src_a    = r_r0;
                src_b    = r_r1;
                src_frac = r_fy;
            end
        endcase
        a_byte = src_a[CH_W*r_cnt[1:0] +: CH_W];
        b_byte = src_b[CH_W*r_cnt[1:0] +: CH_W];
        diff   = {1'b0, b_byte} - {1'b0, a_byte};
        pp_val = r_prod[FRAC_W +: CH_W] + r_la;
    end

    // ------------------------------------------------------------------------
    // sample position clamp, shared by column and row capture
    // ------------------------------------------------------------------------
    always_comb begin
        pos_sum = $unsigned(r_prod) + (PW'(r_step_x) >> 1);
        if (r_state == S_XCAP) begin
            cap_dim = DIMW'(eff_iw);
            cap_int = r_quality ? SW'($unsigned(r_prod) >> FRAC_W) : pos_sum[PW-1:FRAC_W];
        end else begin
            cap_dim = DIMW'(eff_ih);
            cap_int = r_quality ? SW'($unsigned(r_prod) >> FRAC_W) : SW'(r_step_y);
        end
        if (cap_int >= SW'(cap_dim))
            cap_pos = cap_dim - DIMW'(1);
        else
            cap_pos = DIMW'(cap_int);
        cap_next = r_quality && ((32'(cap_pos) + 32'd1) < 32'(cap_dim));
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_div_wait  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FETCH && r_cnt != FETCH_LAST) ||
                (r_state == S_LERP && r_cnt != LERP_LAST))
                r_cnt <= r_cnt + CNT_W'(1);
            else
                r_cnt <= '0;
            if (div_start)
                r_div_wait <= 1'b1;
            else if (div_done)
                r_div_wait <= 1'b0;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            r_lv <= lerp_issue;
        end
    end

    // ------------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (accept) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
        end
        if (r_state == S_DIVX && div_done)
            r_step_x <= div_quotient;
        if (r_state == S_DIVY && div_done)
            r_step_y <= div_quotient;
        if (r_state == S_XCAP) begin
            r_xi <= XW'(cap_pos);
            r_x1 <= cap_next ? XW'(cap_pos + DIMW'(1)) : XW'(cap_pos);
            r_fx <= r_prod[FRAC_W-1:0];
        end
        if (r_state == S_YCAP) begin
            r_yi <= YW'(cap_pos);
            r_y1 <= cap_next ? YW'(cap_pos + DIMW'(1)) : YW'(cap_pos);
            r_fy <= r_prod[FRAC_W-1:0];
        end
        if (fetch_cap)
            r_pix[r_cnt[1:0] - 2'd1] <= r_rd;
        if (lerp_issue) begin
            r_la <= a_byte;
            r_lk <= r_cnt;
        end
        if (r_lv) begin
            case (r_lk[3:2])
                2'd0:    r_r0[CH_W*r_lk[1:0] +: CH_W]  <= pp_val;
                2'd1:    r_r1[CH_W*r_lk[1:0] +: CH_W]  <= pp_val;
                default: r_res[CH_W*r_lk[1:0] +: CH_W] <= pp_val;
            endcase
        end
        if (out_load)
            r_out_pixel <= r_quality ? r_res : r_pix[0];
    end

    // ------------------------------------------------------------------------
    // image memory
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[wr_addr] <= i_pixel_in;
        r_rd <= r_mem[rd_addr];
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

endmodule
`default_nettype wire
